// ----- hdl/stss_pkg.sv -----
// ============================================================================
// stss_pkg
// Shared types and constants for the slope-threshold track splitter.
// ============================================================================
package stss_pkg;

    localparam int unsigned COORD_W      = 32;
    localparam int unsigned THRESH_W     = 32;
    localparam int unsigned FRAC_W       = 16;
    localparam int unsigned MASK_W       = 16;
    localparam int unsigned NEW_INDEX_W  = 4;
    localparam int unsigned IN_USE_W     = 5;
    localparam int unsigned PROD_W       = COORD_W + THRESH_W;
    localparam int unsigned DY_W         = COORD_W + 1;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 32'h0001_0000;

    // Step strobes broadcast from the sequencer to every track cell.
    typedef struct packed {
        logic diff_en;
        logic mul_en;
        logic cmp_en;
        logic commit;
        logic first;
        logic open_new;
    } stss_ctrl_t;

endpackage

// ----- hdl/stss_in_if.sv -----
// ============================================================================
// stss_in_if
// Sample channel: valid/ready handshake with one offset sample per beat.
// ============================================================================
interface stss_in_if;

    logic                                  valid;
    logic                                  ready;
    logic                                  first_sample;
    logic [stss_pkg::COORD_W-1:0]          sample_x;
    logic signed [stss_pkg::COORD_W-1:0]   sample_y;

    modport source (
        output valid,
        input  ready,
        output first_sample,
        output sample_x,
        output sample_y
    );

    modport sink (
        input  valid,
        output ready,
        input  first_sample,
        input  sample_x,
        input  sample_y
    );

endinterface

// ----- hdl/stss_out_if.sv -----
// ============================================================================
// stss_out_if
// Result channel: valid/ready handshake with one track decision per beat.
// ============================================================================
interface stss_out_if;

    logic                                  valid;
    logic                                  ready;
    logic [stss_pkg::MASK_W-1:0]           join_mask;
    logic                                  opened_new;
    logic [stss_pkg::NEW_INDEX_W-1:0]      new_index;
    logic                                  overflow;
    logic [stss_pkg::IN_USE_W-1:0]         tracks_in_use;

    modport source (
        output valid,
        input  ready,
        output join_mask,
        output opened_new,
        output new_index,
        output overflow,
        output tracks_in_use
    );

    modport sink (
        input  valid,
        output ready,
        input  join_mask,
        input  opened_new,
        input  new_index,
        input  overflow,
        input  tracks_in_use
    );

endinterface

// ----- hdl/stss_cell.sv -----
// ============================================================================
// stss_cell
// One track: holds its last point, tests the slope to the current sample
// over three steps and updates itself on commit. Joins ripple to the next
// cell through the any-join chain.
// ============================================================================
module stss_cell #(
    parameter int unsigned CELL_IDX = 0,
    parameter int unsigned CNT_W    = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  stss_pkg::stss_ctrl_t                 ctrl,
    input  logic [stss_pkg::COORD_W-1:0]         sample_x,
    input  logic signed [stss_pkg::COORD_W-1:0]  sample_y,
    input  logic [stss_pkg::THRESH_W-1:0]        threshold,
    input  logic [CNT_W-1:0]                     count,
    input  logic                                 any_in,
    output logic                                 any_out,
    output logic                                 join_hit
);

    logic [stss_pkg::COORD_W-1:0]         last_x_reg;
    logic signed [stss_pkg::COORD_W-1:0]  last_y_reg;
    logic                                 open_reg;
    logic                                 open_next;
    logic                                 write_en;

    logic [stss_pkg::COORD_W-1:0]         dx_reg;
    logic [stss_pkg::DY_W-1:0]            dy_reg;
    logic [stss_pkg::PROD_W-1:0]          prod_reg;
    logic                                 join_reg;

    logic [stss_pkg::COORD_W-1:0]         dx_next;
    logic signed [stss_pkg::DY_W-1:0]     dy_diff;
    logic [stss_pkg::DY_W-1:0]            dy_next;
    logic [stss_pkg::PROD_W-1:0]          dy_scaled;
    logic                                 slope_ok;
    logic                                 is_new_slot;

    always_comb
    begin
        dx_next = (sample_x >= last_x_reg) ? (sample_x - last_x_reg)
                                           : (last_x_reg - sample_x);
        dy_diff = {sample_y[stss_pkg::COORD_W-1], sample_y}
                - {last_y_reg[stss_pkg::COORD_W-1], last_y_reg};
        dy_next = dy_diff[stss_pkg::DY_W-1] ? stss_pkg::DY_W'(-dy_diff)
                                            : stss_pkg::DY_W'(dy_diff);
        dy_scaled = stss_pkg::PROD_W'({dy_reg, {stss_pkg::FRAC_W{1'b0}}});
        // a zero time step always passes the slope test
        slope_ok  = (dx_reg == '0) || (dy_scaled <= prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.diff_en)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= stss_pkg::PROD_W'(threshold) * stss_pkg::PROD_W'(dx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            join_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            join_reg <= open_reg && slope_ok && !ctrl.first;
        end
    end

    assign is_new_slot = (count == CNT_W'(CELL_IDX));

    always_comb
    begin
        open_next = open_reg;
        write_en  = 1'b0;
        if (ctrl.commit)
        begin
            if (ctrl.first)
            begin
                open_next = (CELL_IDX == 0);
                write_en  = (CELL_IDX == 0);
            end
            else if (join_reg)
            begin
                write_en = 1'b1;
            end
            else if (ctrl.open_new && is_new_slot)
            begin
                open_next = 1'b1;
                write_en  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            last_x_reg <= sample_x;
            last_y_reg <= sample_y;
        end
    end

    assign join_hit = join_reg;
    assign any_out  = any_in | join_reg;

endmodule

// ----- hdl/slope_threshold_track_splitter.sv -----
// ============================================================================
// slope_threshold_track_splitter
// Sorts clock-offset samples into tracks by slope against a row of cells.
// ============================================================================
//
//   channel            dir   handshake          beat
//   sample_in          in    valid / ready      first_sample, sample_x, sample_y
//   result_out         out   valid / ready      join_mask .. tracks_in_use
//   slope_threshold    in    we, no ready       32-bit Q16.16 threshold
//
// Each sample passes through the steps accept, difference, multiply, compare
// and commit; the per-cell threshold multiply and its registered compare get
// steps of their own. Reset closes every track and loads the threshold with 1.0.
// A result waiting in the output register does not block the next accept;
// only the commit step waits when that register is still full.
// ============================================================================
module slope_threshold_track_splitter #(
    parameter int unsigned MAX_TRACKS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    stss_in_if.sink                         sample_in,
    stss_out_if.source                      result_out,
    input  logic                            slope_threshold_we,
    input  logic [stss_pkg::THRESH_W-1:0]   slope_threshold_wdata
);

    localparam int unsigned CNT_W = $clog2(MAX_TRACKS + 1);
    localparam int unsigned PAD_W = (MAX_TRACKS > stss_pkg::MASK_W)
                                  ? MAX_TRACKS : stss_pkg::MASK_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DIFF   = 5'b00010,
        S_MUL    = 5'b00100,
        S_CMP    = 5'b01000,
        S_COMMIT = 5'b10000
    } state_t;

    state_t                                 state_reg, state_next;
    logic [stss_pkg::THRESH_W-1:0]          threshold_reg;
    logic                                   first_reg;
    logic [stss_pkg::COORD_W-1:0]           x_reg;
    logic signed [stss_pkg::COORD_W-1:0]    y_reg;
    logic [CNT_W-1:0]                       count_reg, count_next;

    logic                                   out_valid_reg;
    logic [stss_pkg::MASK_W-1:0]            mask_reg;
    logic                                   opened_reg;
    logic [stss_pkg::NEW_INDEX_W-1:0]       index_reg;
    logic                                   overflow_reg;
    logic [stss_pkg::IN_USE_W-1:0]          in_use_reg;

    stss_pkg::stss_ctrl_t                   ctrl;
    logic [MAX_TRACKS:0]                    any_chain;
    logic [MAX_TRACKS-1:0]                  join_vec;
    logic [PAD_W-1:0]                       join_pad;
    logic                                   out_free;
    logic                                   accept;
    logic                                   any_join;
    logic                                   full;
    logic                                   ovf_now;
    logic [CNT_W+stss_pkg::IN_USE_W-1:0]    in_use_wide;
    logic [CNT_W+stss_pkg::NEW_INDEX_W-1:0] index_wide;

    assign accept   = sample_in.valid && sample_in.ready;
    assign out_free = !out_valid_reg || result_out.ready;
    assign any_join = any_chain[MAX_TRACKS];
    assign full     = (count_reg == CNT_W'(MAX_TRACKS));
    assign ovf_now  = !first_reg && !any_join && full;

    assign ctrl.diff_en  = (state_reg == S_DIFF);
    assign ctrl.mul_en   = (state_reg == S_MUL);
    assign ctrl.cmp_en   = (state_reg == S_CMP);
    assign ctrl.commit   = (state_reg == S_COMMIT) && out_free;
    assign ctrl.first    = first_reg;
    assign ctrl.open_new = !any_join && !full;

    assign any_chain[0] = 1'b0;

    for (genvar j = 0; j < MAX_TRACKS; j++)
    begin : g_cell
        stss_cell #(
            .CELL_IDX (j),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .sample_x  (x_reg),
            .sample_y  (y_reg),
            .threshold (threshold_reg),
            .count     (count_reg),
            .any_in    (any_chain[j]),
            .any_out   (any_chain[j+1]),
            .join_hit  (join_vec[j])
        );
    end

    assign join_pad = PAD_W'(join_vec);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = S_DIFF;
            S_DIFF:   state_next = S_MUL;
            S_MUL:    state_next = S_CMP;
            S_CMP:    state_next = S_COMMIT;
            S_COMMIT: if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.commit)
        begin
            if (first_reg)
            begin
                count_next = CNT_W'(1);
            end
            else if (ctrl.open_new)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        in_use_wide = (CNT_W + stss_pkg::IN_USE_W)'(count_next);
        index_wide  = (CNT_W + stss_pkg::NEW_INDEX_W)'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            threshold_reg <= stss_pkg::THRESH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (slope_threshold_we)
            begin
                threshold_reg <= slope_threshold_wdata;
            end
            if (ctrl.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the sample for the whole evaluation
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            first_reg <= sample_in.first_sample;
            x_reg     <= sample_in.sample_x;
            y_reg     <= sample_in.sample_y;
        end
        if (ctrl.commit)
        begin
            mask_reg     <= first_reg ? '0 : join_pad[stss_pkg::MASK_W-1:0];
            opened_reg   <= first_reg || ctrl.open_new;
            index_reg    <= (!first_reg && ctrl.open_new)
                          ? index_wide[stss_pkg::NEW_INDEX_W-1:0] : '0;
            overflow_reg <= ovf_now;
            in_use_reg   <= in_use_wide[stss_pkg::IN_USE_W-1:0];
        end
    end

    assign sample_in.ready          = (state_reg == S_IDLE);
    assign result_out.valid         = out_valid_reg;
    assign result_out.join_mask     = mask_reg;
    assign result_out.opened_new    = opened_reg;
    assign result_out.new_index     = index_reg;
    assign result_out.overflow      = overflow_reg;
    assign result_out.tracks_in_use = in_use_reg;

endmodule
